// File: rtl/core/qpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_pkg - shared types and constants of the quadratic probe hash table
// Table geometry, field widths, operation codes, register map and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package qpht_pkg;

  // Table geometry; slot arithmetic wraps, so the slot count is a power of two
  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int COUNT_W     = $clog2(TABLE_SLOTS + 1);

  // Field widths
  localparam int OP_W        = 2;
  localparam int KEY_W       = 40;
  localparam int DATA_W      = 32;
  localparam int MOD_W       = 7;
  localparam int SLOT_OUT_W  = 6;
  localparam int COUNT_OUT_W = 7;
  localparam int ENTRY_W     = KEY_W + DATA_W;

  // Hash: key mod 10000 digit by digit (one nibble a cycle), then mod modulus
  localparam int DIGIT_MOD   = 10000;
  localparam int REM_W       = 14;
  localparam int NIB_W       = 4;
  localparam int WIDE_W      = REM_W + NIB_W;
  localparam int DIG_STEPS   = KEY_W / NIB_W;
  localparam int MOD_STEPS   = (REM_W + NIB_W - 1) / NIB_W;
  localparam int MSH_W       = MOD_STEPS * NIB_W;
  localparam int STEP_W      = $clog2(DIG_STEPS);

  // Register map
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam logic [PADDR_W-3:0] REG_HASH_MODULUS = 1'b0;
  localparam logic [MOD_W-1:0]   MOD_RESET        = 7'd61;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic ST_OK   = 1'b0;
  localparam logic ST_FAIL = 1'b1;

  // Controller -> datapath
  typedef struct packed {
    logic load;        // capture request, start digit reduction
    logic dig_step;    // one nibble of mod 10000
    logic mod_start;   // load remainder into modulus divider
    logic mod_step;    // one nibble of mod hash_modulus
    logic probe_start; // latch home slot, probe 0
    logic probe_next;  // advance to next quadratic probe
    logic rd_issue;    // read key/data of current slot
    logic do_insert;   // write entry, mark occupied
    logic do_delete;   // free current slot
    logic out_load;    // fill result register
    logic out_fail;
    logic out_found;
  } qpht_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_t  op;
    logic dig_last;
    logic mod_last;
    logic slot_free;
    logic key_match;
    logic probe_last;
    logic out_busy;
  } qpht_sts_t;

endpackage

// File: rtl/core/qpht_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_req_if - request channel
// Valid/ready channel carrying one table operation.
// ----------------------------------------------------------------------------
interface qpht_req_if;
  logic                        valid;
  logic                        ready;
  logic [qpht_pkg::OP_W-1:0]   operation;
  logic [qpht_pkg::KEY_W-1:0]  phone_number;
  logic [qpht_pkg::DATA_W-1:0] entry_payload;

  modport source (output valid, output operation, output phone_number,
                  output entry_payload, input ready);
  modport sink   (input valid, input operation, input phone_number,
                  input entry_payload, output ready);
endinterface

// File: rtl/core/qpht_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_rsp_if - response channel
// Valid/ready channel carrying one operation result.
// ----------------------------------------------------------------------------
interface qpht_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             status;
  logic [qpht_pkg::SLOT_OUT_W-1:0]  slot_index;
  logic [qpht_pkg::DATA_W-1:0]      found_payload;
  logic [qpht_pkg::COUNT_OUT_W-1:0] entry_count;

  modport source (output valid, output status, output slot_index,
                  output found_payload, output entry_count, input ready);
  modport sink   (input valid, input status, input slot_index,
                  input found_payload, input entry_count, output ready);
endinterface

// File: rtl/core/qpht_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module qpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/qpht_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_dp - datapath of the hash table
// Hash reduction units, quadratic probe generator, occupancy bits, entry
// RAM, entry counter and the result register.
// ----------------------------------------------------------------------------
module qpht_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  qpht_pkg::qpht_cmd_t              cmd,
  output qpht_pkg::qpht_sts_t              sts,
  input  logic [qpht_pkg::OP_W-1:0]        in_operation,
  input  logic [qpht_pkg::KEY_W-1:0]       in_phone_number,
  input  logic [qpht_pkg::DATA_W-1:0]      in_entry_payload,
  input  logic [qpht_pkg::MOD_W-1:0]       hash_modulus,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_status,
  output logic [qpht_pkg::SLOT_OUT_W-1:0]  out_slot_index,
  output logic [qpht_pkg::DATA_W-1:0]      out_found_payload,
  output logic [qpht_pkg::COUNT_OUT_W-1:0] out_entry_count
);

  // (16*r + nib) mod 10000 for r < 10000: four conditional subtracts
  function automatic logic [qpht_pkg::REM_W-1:0] dig_reduce(
    input logic [qpht_pkg::REM_W-1:0] r,
    input logic [qpht_pkg::NIB_W-1:0] nib
  );
    logic [qpht_pkg::WIDE_W-1:0] v;
    v = {r, nib};
    for (int k = qpht_pkg::NIB_W - 1; k >= 0; k--) begin
      if (v >= qpht_pkg::WIDE_W'(qpht_pkg::DIGIT_MOD << k)) begin
        v = v - qpht_pkg::WIDE_W'(qpht_pkg::DIGIT_MOD << k);
      end
    end
    return v[qpht_pkg::REM_W-1:0];
  endfunction

  // Restoring division, one bit per inner step, remainder kept below m
  function automatic logic [qpht_pkg::MOD_W-1:0] mod_reduce(
    input logic [qpht_pkg::MOD_W-1:0] r,
    input logic [qpht_pkg::NIB_W-1:0] bits,
    input logic [qpht_pkg::MOD_W-1:0] m
  );
    logic [qpht_pkg::MOD_W:0] v;
    v = {1'b0, r};
    for (int k = qpht_pkg::NIB_W - 1; k >= 0; k--) begin
      v = {v[qpht_pkg::MOD_W-1:0], bits[k]};
      if (v >= {1'b0, m}) begin
        v = v - {1'b0, m};
      end
    end
    return v[qpht_pkg::MOD_W-1:0];
  endfunction

  // Request
  qpht_pkg::op_t                   op;
  logic [qpht_pkg::KEY_W-1:0]      key;
  logic [qpht_pkg::DATA_W-1:0]     payload;

  // Hash units
  logic [qpht_pkg::KEY_W-1:0]      key_sh;
  logic [qpht_pkg::REM_W-1:0]      rem_dig;
  logic [qpht_pkg::MSH_W-1:0]      msh;
  logic [qpht_pkg::MOD_W-1:0]      rem_mod;
  logic [qpht_pkg::STEP_W-1:0]     step;
  logic [qpht_pkg::MOD_W-1:0]      mod_eff;
  logic [qpht_pkg::MOD_W+qpht_pkg::SLOT_W-1:0] home_ext;

  // Probe generator
  logic [qpht_pkg::SLOT_W-1:0]     home;
  logic [qpht_pkg::SLOT_W-1:0]     sq;
  logic [qpht_pkg::SLOT_W-1:0]     pidx;
  logic [qpht_pkg::SLOT_W-1:0]     slot;

  // Table state
  logic [qpht_pkg::TABLE_SLOTS-1:0] occupied;
  logic [qpht_pkg::COUNT_W-1:0]     count;
  logic [qpht_pkg::ENTRY_W-1:0]     rdata;

  logic [qpht_pkg::SLOT_W+qpht_pkg::SLOT_OUT_W-1:0]   slot_ext;
  logic [qpht_pkg::COUNT_W+qpht_pkg::COUNT_OUT_W-1:0] count_ext;

  assign mod_eff  = (hash_modulus == '0) ? qpht_pkg::MOD_W'(1) : hash_modulus;
  assign home_ext = {{qpht_pkg::SLOT_W{1'b0}}, rem_mod};
  assign slot     = home + sq;
  assign slot_ext = {{qpht_pkg::SLOT_OUT_W{1'b0}}, slot};
  assign count_ext = {{qpht_pkg::COUNT_OUT_W{1'b0}}, count};

  assign sts.op         = op;
  assign sts.dig_last   = (step == qpht_pkg::STEP_W'(qpht_pkg::DIG_STEPS - 1));
  assign sts.mod_last   = (step == qpht_pkg::STEP_W'(qpht_pkg::MOD_STEPS - 1));
  assign sts.slot_free  = !occupied[slot];
  assign sts.key_match  = (rdata[qpht_pkg::ENTRY_W-1 -: qpht_pkg::KEY_W] == key);
  assign sts.probe_last = (pidx == qpht_pkg::SLOT_W'(qpht_pkg::TABLE_SLOTS - 1));
  assign sts.out_busy   = out_valid && !out_ready;

  // Request capture and hash reduction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= qpht_pkg::op_t'(in_operation);
      key     <= in_phone_number;
      payload <= in_entry_payload;
      key_sh  <= in_phone_number;
      rem_dig <= '0;
      step    <= '0;
    end else if (cmd.dig_step) begin
      key_sh  <= key_sh << qpht_pkg::NIB_W;
      rem_dig <= dig_reduce(rem_dig, key_sh[qpht_pkg::KEY_W-1 -: qpht_pkg::NIB_W]);
      step    <= step + 1'b1;
    end else if (cmd.mod_start) begin
      msh     <= {{(qpht_pkg::MSH_W - qpht_pkg::REM_W){1'b0}}, rem_dig};
      rem_mod <= '0;
      step    <= '0;
    end else if (cmd.mod_step) begin
      msh     <= msh << qpht_pkg::NIB_W;
      rem_mod <= mod_reduce(rem_mod, msh[qpht_pkg::MSH_W-1 -: qpht_pkg::NIB_W], mod_eff);
      step    <= step + 1'b1;
    end
  end

  // Probe sequence: offset i*i kept incrementally, step 2i+1
  always_ff @(posedge clk) begin
    if (cmd.probe_start) begin
      home <= home_ext[qpht_pkg::SLOT_W-1:0];
      sq   <= '0;
      pidx <= '0;
    end else if (cmd.probe_next) begin
      sq   <= sq + {pidx[qpht_pkg::SLOT_W-2:0], 1'b1};
      pidx <= pidx + 1'b1;
    end
  end

  // Occupancy and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
      count    <= '0;
    end else if (cmd.do_insert) begin
      occupied[slot] <= 1'b1;
      count          <= count + 1'b1;
    end else if (cmd.do_delete) begin
      occupied[slot] <= 1'b0;
      if (count != '0) begin
        count <= count - 1'b1;
      end
    end
  end

  qpht_ram #(
    .WIDTH (qpht_pkg::ENTRY_W),
    .DEPTH (qpht_pkg::TABLE_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (cmd.do_insert),
    .waddr (slot),
    .wdata ({key, payload}),
    .re    (cmd.rd_issue),
    .raddr (slot),
    .rdata (rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status        <= cmd.out_fail ? qpht_pkg::ST_FAIL : qpht_pkg::ST_OK;
      out_slot_index    <= cmd.out_fail ? '0 : slot_ext[qpht_pkg::SLOT_OUT_W-1:0];
      out_found_payload <= cmd.out_found ? rdata[qpht_pkg::DATA_W-1:0] : '0;
      out_entry_count   <= count_ext[qpht_pkg::COUNT_OUT_W-1:0];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= qpht_pkg::COUNT_W'(qpht_pkg::TABLE_SLOTS))
    else $error("entry count above table size");

  a_insert_free: assert property (@(posedge clk) disable iff (rst)
    cmd.do_insert |-> !occupied[slot])
    else $error("insert into occupied slot");

  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    cmd.do_delete |=> count == $past(count) - 1'b1)
    else $error("delete did not reduce count");

endmodule

// File: rtl/core/qpht_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qpht_ctrl - operation sequencer
// Steps the hash units, walks the probe sequence and decides the outcome.
// ----------------------------------------------------------------------------
module qpht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output qpht_pkg::qpht_cmd_t cmd,
  input  qpht_pkg::qpht_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIG,
    S_MOD_INIT,
    S_MOD,
    S_PROBE_START,
    S_PROBE,
    S_CMP,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   res_fail, res_fail_next;
  logic   res_found, res_found_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    res_fail_next  = res_fail;
    res_found_next = res_found;
    cmd            = '0;
    cmd.out_fail   = res_fail;
    cmd.out_found  = res_found;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          res_fail_next  = 1'b0;
          res_found_next = 1'b0;
          state_next     = S_DIG;
        end
      end
      S_DIG: begin
        cmd.dig_step = 1'b1;
        if (sts.dig_last) begin
          state_next = S_MOD_INIT;
        end
      end
      S_MOD_INIT: begin
        cmd.mod_start = 1'b1;
        state_next    = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = S_PROBE_START;
        end
      end
      S_PROBE_START: begin
        cmd.probe_start = 1'b1;
        if (sts.op == qpht_pkg::OP_NONE) begin
          res_fail_next = 1'b1;
          state_next    = S_DONE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.op == qpht_pkg::OP_INSERT) begin
          priority if (sts.slot_free) begin
            cmd.do_insert = 1'b1;
            state_next    = S_DONE;
          end else if (sts.probe_last) begin
            res_fail_next = 1'b1;
            state_next    = S_DONE;
          end else begin
            cmd.probe_next = 1'b1;
          end
        end else if (sts.slot_free) begin
          res_fail_next = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next   = S_CMP;
        end
      end
      S_CMP: begin
        priority if (sts.key_match) begin
          res_found_next = (sts.op == qpht_pkg::OP_SEARCH);
          cmd.do_delete  = (sts.op == qpht_pkg::OP_DELETE);
          state_next     = S_DONE;
        end else if (sts.probe_last) begin
          res_fail_next = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_PROBE;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_fail  <= 1'b0;
      res_found <= 1'b0;
    end else begin
      state     <= state_next;
      res_fail  <= res_fail_next;
      res_found <= res_found_next;
    end
  end

  a_one_commit: assert property (@(posedge clk) disable iff (rst)
    !(cmd.do_insert && cmd.do_delete))
    else $error("insert and delete in one cycle");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !sts.out_busy)
    else $error("result register overwritten");

  a_busy_after_load: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while one is in flight");

endmodule

// File: rtl/core/quadratic_probe_hash_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit - open-addressing phone number hash table
// Insert, search and delete on a 64-slot table with quadratic probing.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. After the request transfer the key
// is reduced mod 10000 one decimal-free nibble a cycle, then mod
// hash_modulus in S_MOD_INIT and S_MOD, and probing starts from
// S_PROBE_START. Each insert probe checks only the occupancy bits (flops);
// each search or delete probe that hits an occupied slot adds an S_CMP
// state for the registered read of the entry RAM. After the decision the
// result is loaded in S_DONE once the output register is free. At most 64
// probes are visited. A finished result sits in an output register, so the
// next request is taken while the previous result still waits for its
// transfer. The table comes up empty straight out of reset; no clearing
// pass is needed.
// hash_modulus (register 0, byte address 0, reset 61) should be written only
// while no request is in flight. A modulus of zero acts as one.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_unit (
  input  logic                            clk,
  input  logic                            rst,
  qpht_req_if.sink                        req,
  qpht_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [qpht_pkg::PADDR_W-1:0]    paddr,
  input  logic [qpht_pkg::PDATA_W-1:0]    pwdata,
  output logic [qpht_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  qpht_pkg::qpht_cmd_t          cmd;
  qpht_pkg::qpht_sts_t          sts;
  logic [qpht_pkg::MOD_W-1:0]   hash_modulus;
  logic                         reg_hit;

  // Config port: zero-wait APB, one register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[qpht_pkg::PADDR_W-1:2] == qpht_pkg::REG_HASH_MODULUS);
  assign prdata  = reg_hit ? {{(qpht_pkg::PDATA_W - qpht_pkg::MOD_W){1'b0}}, hash_modulus}
                           : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_modulus <= qpht_pkg::MOD_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      hash_modulus <= pwdata[qpht_pkg::MOD_W-1:0];
    end
  end

  // Sequencer: hash steps, probe walk, outcome
  qpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Hash units, probe generator, table storage, result register
  qpht_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (req.operation),
    .in_phone_number   (req.phone_number),
    .in_entry_payload  (req.entry_payload),
    .hash_modulus      (hash_modulus),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_status        (rsp.status),
    .out_slot_index    (rsp.slot_index),
    .out_found_payload (rsp.found_payload),
    .out_entry_count   (rsp.entry_count)
  );

endmodule
